// ----- rtl/core/psch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psch_pkg
// Types and codes shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_ORDER = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] task_id;
        logic [31:0] arrival_time;
        logic [31:0] run_length;
        logic [15:0] priority_req;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] done_id;
        logic [39:0] finish_time;
        logic        last_of_run;
    } out_t;

    // One ready-queue slot
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [31:0] remaining;
        logic [15:0] prio;
        logic [15:0] seq;
    } entry_t;

endpackage

// ----- rtl/core/psch_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/psch_rank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psch_rank
// Shared compare unit: candidate beats current best on priority, then
// earlier arrival, then earlier input sequence.
// ----------------------------------------------------------------------------
module psch_rank
    import psch_pkg::*;
(
    input  entry_t cand,
    input  entry_t best,
    output logic   wins
);

    always_comb begin
        if (cand.prio != best.prio) begin
            wins = cand.prio > best.prio;
        end else if (cand.arrival != best.arrival) begin
            wins = cand.arrival < best.arrival;
        end else begin
            wins = cand.seq < best.seq;
        end
    end

endmodule

// ----- rtl/core/preemptive_priority_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Preemptive priority scheduler with first-come tie-break.
//
// Input channel s_valid/s_ready/s_payload takes one request at a time: a task
// arrival or a drain. Result channel m_valid/m_ready/m_payload returns task
// completions and rejections; last_of_run marks the final result of a request.
// A request that yields no result (arrival queued with no completion, drain
// of an empty queue) produces nothing on m_*.
// s_ready is high only while the sequencer is idle. An arrival onto an empty
// queue goes from idle straight to the queue write. Each pick of the best
// queued task is a scan through the queue RAM by the one compare unit; a
// completed slot other than the tail is refilled from the tail. An
// out-of-order arrival is rejected without a scan. Results pass through a
// one-deep hold and an output register. A stalled receiver stops the
// sequencer only when both the hold and the output register are full; no
// result is dropped. Reset (aresetn low, synchronous) empties the queue,
// zeroes the clock and sequence, and clears any pending result. Queue RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top
    import psch_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_SUM     = 4'd2;
    localparam logic [3:0] ST_DECIDE  = 4'd3;
    localparam logic [3:0] ST_TRIM    = 4'd4;
    localparam logic [3:0] ST_DROP_RD = 4'd5;
    localparam logic [3:0] ST_DROP_WR = 4'd6;
    localparam logic [3:0] ST_ARRIVE  = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    logic [3:0]    state_reg, state_next;
    in_t           req_reg, req_next;
    logic [39:0]   ct_reg, ct_next;
    logic [31:0]   last_arr_reg, last_arr_next;
    logic [15:0]   seq_reg, seq_next;
    logic          batch_reg, batch_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    entry_t        best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [40:0]   end_reg, end_next;
    logic          hold_valid_reg, hold_valid_next;
    out_t          hold_reg, hold_next;
    logic          m_valid_reg, m_valid_next;
    out_t          out_reg, out_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_rdata;
    logic          rank_win;

    logic          out_free;
    logic          can_push;
    logic          new_res_en;
    out_t          new_res;
    logic [CW-1:0] count_dec;
    logic [3:0]    after_drop;
    logic          is_drain;

    psch_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psch_rank u_rank (
        .cand (ram_rdata),
        .best (best_reg),
        .wins (rank_win)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign can_push  = !hold_valid_reg || out_free;
    assign count_dec = count_reg - 1'b1;
    assign is_drain  = (req_reg.cmd == CMD_DRAIN);

    always_comb begin
        if (count_dec != '0) begin
            after_drop = ST_SCAN;
        end else if (is_drain) begin
            after_drop = ST_FINISH;
        end else begin
            after_drop = ST_ARRIVE;
        end
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        ct_next         = ct_reg;
        last_arr_next   = last_arr_reg;
        seq_next        = seq_reg;
        batch_next      = batch_reg;
        count_next      = count_reg;
        ri_next         = ri_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        end_next        = end_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = best_reg;
        ram_raddr       = ri_reg[IW-1:0];
        new_res_en      = 1'b0;
        new_res         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                ri_next        = '0;
                cmp_valid_next = 1'b0;
                if (s_valid) begin
                    req_next = s_payload;
                    if (s_payload.cmd == CMD_DRAIN) begin
                        state_next = (count_reg != '0) ? ST_SCAN : ST_FINISH;
                    end else if (batch_reg && (s_payload.arrival_time < last_arr_reg)) begin
                        hold_valid_next       = 1'b1;
                        hold_next.kind        = KIND_ORDER;
                        hold_next.done_id     = s_payload.task_id;
                        hold_next.finish_time = '0;
                        hold_next.last_of_run = 1'b0;
                        state_next            = ST_FINISH;
                    end else begin
                        state_next = (count_reg != '0) ? ST_SCAN : ST_ARRIVE;
                    end
                end
            end
            ST_SCAN: begin
                if (ri_reg != count_reg) begin
                    ri_next        = ri_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = ri_reg[IW-1:0];
                end else begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg && ((cmp_idx_reg == '0) || rank_win)) begin
                    best_next     = ram_rdata;
                    best_idx_next = cmp_idx_reg;
                end
                if ((ri_reg == count_reg) && !cmp_valid_reg) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                end_next   = {1'b0, ct_reg} + {9'd0, best_reg.remaining};
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                ri_next        = '0;
                cmp_valid_next = 1'b0;
                if (is_drain || (end_reg <= {9'd0, req_reg.arrival_time})) begin
                    new_res_en          = 1'b1;
                    new_res.kind        = KIND_DONE;
                    new_res.done_id     = best_reg.id;
                    new_res.finish_time = end_reg[39:0];
                    new_res.last_of_run = 1'b0;
                    if (can_push) begin
                        ct_next    = end_reg[39:0];
                        count_next = count_dec;
                        if (best_idx_reg == count_dec[IW-1:0]) begin
                            state_next = after_drop;
                        end else begin
                            state_next = ST_DROP_RD;
                        end
                    end
                end else begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (ct_reg < {8'd0, req_reg.arrival_time}) begin
                    ram_we              = 1'b1;
                    ram_wdata.remaining = end_reg[31:0] - req_reg.arrival_time;
                end
                state_next = ST_ARRIVE;
            end
            ST_DROP_RD: begin
                ram_raddr  = count_reg[IW-1:0];
                state_next = ST_DROP_WR;
            end
            ST_DROP_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                ri_next    = '0;
                if (count_reg != '0) begin
                    state_next = ST_SCAN;
                end else if (is_drain) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_ARRIVE;
                end
            end
            ST_ARRIVE: begin
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    new_res_en          = 1'b1;
                    new_res.kind        = KIND_FULL;
                    new_res.done_id     = req_reg.task_id;
                    new_res.finish_time = '0;
                    new_res.last_of_run = 1'b0;
                end else begin
                    ram_waddr           = count_reg[IW-1:0];
                    ram_wdata.id        = req_reg.task_id;
                    ram_wdata.arrival   = req_reg.arrival_time;
                    ram_wdata.remaining = req_reg.run_length;
                    ram_wdata.prio      = req_reg.priority_req;
                    ram_wdata.seq       = seq_reg;
                end
                if (!new_res_en || can_push) begin
                    ram_we        = !new_res_en;
                    count_next    = new_res_en ? count_reg : count_reg + 1'b1;
                    ct_next       = {8'd0, req_reg.arrival_time};
                    last_arr_next = req_reg.arrival_time;
                    batch_next    = 1'b1;
                    seq_next      = seq_reg + 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        out_next             = hold_reg;
                        out_next.last_of_run = 1'b1;
                        m_valid_next         = 1'b1;
                        hold_valid_next      = 1'b0;
                    end
                    if (is_drain) begin
                        ct_next       = '0;
                        count_next    = '0;
                        last_arr_next = '0;
                        seq_next      = '0;
                        batch_next    = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (new_res_en && can_push) begin
            if (hold_valid_reg) begin
                out_next     = hold_reg;
                m_valid_next = 1'b1;
            end
            hold_next       = new_res;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ct_reg         <= '0;
            last_arr_reg   <= '0;
            seq_reg        <= '0;
            batch_reg      <= 1'b0;
            count_reg      <= '0;
            ri_reg         <= '0;
            cmp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ct_reg         <= ct_next;
            last_arr_reg   <= last_arr_next;
            seq_reg        <= seq_next;
            batch_reg      <= batch_next;
            count_reg      <= count_next;
            ri_reg         <= ri_next;
            cmp_valid_reg  <= cmp_valid_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        end_reg      <= end_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
    end

endmodule

// ----- rtl/core/psch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psch_checker
// Port-level checks for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
module psch_checker
    import psch_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_payload,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind != KIND_DONE) |-> m_payload.last_of_run)
        else $error("rejection not last of run");

    a_reject_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind != KIND_DONE) |-> (m_payload.finish_time == '0))
        else $error("rejection carries a finish time");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind preemptive_priority_scheduler_top psch_checker u_psch_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// ----- test/preemptive_priority_scheduler_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top_test
// Self-checking bench for the preemptive priority scheduler.
//
// A directed table covers ordering, out-of-order and queue-full rejection,
// drains and field extremes. Random batches of arrivals follow. An in-bench
// scheduler computes the completions due for each accepted request; results
// are checked in order.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top_test;
    import psch_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        in_t  req;
        bit   typed_ok;
        out_t typed;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    // scheduler state kept by the bench
    logic [39:0] sched_now;
    entry_t      ready_q [DEPTH];
    int          ready_n;
    logic [31:0] last_arr;
    logic [15:0] next_seq;
    bit          batch_open;

    out_t        step_out[$];
    out_t        due_results[$];
    plan_row_t   plan[$];

    int          mismatch_count = 0;
    int unsigned burst_left = 0;
    bit          hold_off_req = 1'b0;

    preemptive_priority_scheduler_top #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic in_t make_req(input logic cmd, input logic [15:0] id,
                                     input logic [31:0] t, input logic [31:0] len,
                                     input logic [15:0] pri);
        in_t r;
        r.cmd          = cmd;
        r.task_id      = id;
        r.arrival_time = t;
        r.run_length   = len;
        r.priority_req = pri;
        return r;
    endfunction

    function automatic out_t one_result(input logic [1:0] kind, input logic [15:0] id,
                                        input logic [39:0] t);
        out_t r;
        r.kind        = kind;
        r.done_id     = id;
        r.finish_time = t;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic bit wins_over(input int a, input int b);
        if (ready_q[a].prio != ready_q[b].prio)
            return ready_q[a].prio > ready_q[b].prio;
        if (ready_q[a].arrival != ready_q[b].arrival)
            return ready_q[a].arrival < ready_q[b].arrival;
        return ready_q[a].seq < ready_q[b].seq;
    endfunction

    function automatic int top_slot();
        int b;
        b = 0;
        for (int i = 1; i < ready_n; i++) begin
            if (wins_over(i, b))
                b = i;
        end
        return b;
    endfunction

    task automatic retire_top();
        int   b;
        out_t r;
        b = top_slot();
        sched_now     = sched_now + {8'd0, ready_q[b].remaining};
        r.kind        = KIND_DONE;
        r.done_id     = ready_q[b].id;
        r.finish_time = sched_now;
        r.last_of_run = 1'b0;
        step_out.push_back(r);
        ready_n = ready_n - 1;
        if (b != ready_n)
            ready_q[b] = ready_q[ready_n];
    endtask

    // results caused by one accepted request land in step_out
    task automatic advance_scheduler(input in_t req);
        int          b;
        bit          blocked;
        logic [40:0] ends;
        out_t        r;
        step_out.delete();
        blocked = 1'b0;
        if (req.cmd == CMD_DRAIN) begin
            while (ready_n > 0)
                retire_top();
            sched_now  = '0;
            last_arr   = '0;
            next_seq   = '0;
            batch_open = 1'b0;
        end else if (batch_open && req.arrival_time < last_arr) begin
            step_out.push_back(one_result(KIND_ORDER, req.task_id, 40'd0));
        end else begin
            while (ready_n > 0 && !blocked) begin
                b    = top_slot();
                ends = {1'b0, sched_now} + {9'd0, ready_q[b].remaining};
                if (ends <= {9'd0, req.arrival_time}) begin
                    retire_top();
                end else begin
                    if (sched_now < {8'd0, req.arrival_time})
                        ready_q[b].remaining = ready_q[b].remaining
                                             - (req.arrival_time - sched_now[31:0]);
                    blocked = 1'b1;
                end
            end
            sched_now  = {8'd0, req.arrival_time};
            last_arr   = req.arrival_time;
            batch_open = 1'b1;
            if (ready_n >= DEPTH) begin
                step_out.push_back(one_result(KIND_FULL, req.task_id, 40'd0));
            end else begin
                ready_q[ready_n].id        = req.task_id;
                ready_q[ready_n].arrival   = req.arrival_time;
                ready_q[ready_n].remaining = req.run_length;
                ready_q[ready_n].prio      = req.priority_req;
                ready_q[ready_n].seq       = next_seq;
                ready_n = ready_n + 1;
            end
            next_seq = next_seq + 16'd1;
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last_of_run = 1'b1;
            step_out.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    task automatic offer(input in_t req, input bit typed_ok, input out_t typed);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
        s_payload <= req;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_scheduler(req);
        if (typed_ok)
            due_results.push_back(typed);
        else
            foreach (step_out[i]) due_results.push_back(step_out[i]);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result id %h", m_payload.done_id));
            end else begin
                want = due_results.pop_front();
                if (m_payload.kind !== want.kind)
                    report_mismatch($sformatf("kind got %0d want %0d (id %h)",
                                              m_payload.kind, want.kind, want.done_id));
                if (m_payload.done_id !== want.done_id)
                    report_mismatch($sformatf("done_id got %h want %h",
                                              m_payload.done_id, want.done_id));
                if (m_payload.finish_time !== want.finish_time)
                    report_mismatch($sformatf("finish_time got %h want %h (id %h)",
                                              m_payload.finish_time, want.finish_time,
                                              want.done_id));
                if (m_payload.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %b want %b (id %h)",
                                              m_payload.last_of_run, want.last_of_run,
                                              want.done_id));
            end
        end
    end

    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        bit          rdy;
        m_ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 1) == 1);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (tick % 5) < 3;
                endcase
                m_ready <= rdy;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("[preemptive_priority_scheduler_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        out_t        none;
        in_t         req;
        logic [31:0] t_next;
        logic [31:0] t_req;
        logic [31:0] len;
        logic [15:0] pri;
        int unsigned n_tasks;
        int unsigned roll;
        int unsigned rand_sent;
        bit          held;
        bit          paused;

        none       = '0;
        sched_now  = '0;
        ready_n    = 0;
        last_arr   = '0;
        next_seq   = '0;
        batch_open = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;

        // directed table
        plan.push_back({make_req(CMD_ARRIVE, 16'h0000, 32'd0, 32'd0, 16'h0000), 1'b0, none});
        plan.push_back({make_req(CMD_ARRIVE, 16'h0002, 32'd0, 32'd5, 16'hFFFF), 1'b1,
                        one_result(KIND_DONE, 16'h0000, 40'd0)});
        plan.push_back({make_req(CMD_ARRIVE, 16'h0003, 32'd3, 32'd10, 16'h0007), 1'b0, none});
        plan.push_back({make_req(CMD_ARRIVE, 16'h0004, 32'd2, 32'd1, 16'h0001), 1'b1,
                        one_result(KIND_ORDER, 16'h0004, 40'd0)});
        plan.push_back({make_req(CMD_DRAIN, 16'h0000, 32'd0, 32'd0, 16'h0000), 1'b0, none});
        plan.push_back({make_req(CMD_DRAIN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
                        1'b0, none});
        plan.push_back({make_req(CMD_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000),
                        1'b0, none});
        plan.push_back({make_req(CMD_DRAIN, 16'h0000, 32'd0, 32'd0, 16'h0000), 1'b1,
                        one_result(KIND_DONE, 16'hFFFF, 40'h1_FFFF_FFFE)});
        for (int i = 0; i < DEPTH; i++)
            plan.push_back({make_req(CMD_ARRIVE, 16'(16'h0100 + i), 32'd100, 32'(i + 1),
                                     16'(i % 3)), 1'b0, none});
        plan.push_back({make_req(CMD_ARRIVE, 16'h0200, 32'd100, 32'd1, 16'hFFFF), 1'b1,
                        one_result(KIND_FULL, 16'h0200, 40'd0)});
        plan.push_back({make_req(CMD_DRAIN, 16'h0000, 32'd0, 32'd0, 16'h0000), 1'b0, none});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) offer(plan[i].req, plan[i].typed_ok, plan[i].typed);
        settle();

        // random batches of arrivals, mostly closed by a drain
        rand_sent = 0;
        held      = 1'b0;
        paused    = 1'b0;
        while (rand_sent < 120) begin
            n_tasks = $urandom_range(1, 20);
            t_next  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 500);
            for (int i = 0; i < n_tasks; i++) begin
                if (!held && rand_sent >= 30) begin
                    held = 1'b1;
                    hold_off_req = 1'b1;
                end
                if (!paused && rand_sent >= 80) begin
                    paused = 1'b1;
                    settle();
                end
                roll = $urandom_range(0, 19);
                if (roll >= 7)
                    t_next = t_next + $urandom_range(1, 40);
                t_req = (roll == 0) ? t_next - $urandom_range(1, 50) : t_next;
                len   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
                pri   = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3));
                req   = make_req(CMD_ARRIVE, 16'($urandom), t_req, len, pri);
                offer(req, 1'b0, none);
                rand_sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
                req = make_req(CMD_DRAIN, 16'($urandom), $urandom, $urandom, 16'($urandom));
                offer(req, 1'b0, none);
                rand_sent++;
            end
        end
        settle();

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("[preemptive_priority_scheduler_top] OK");
        else
            $display("[preemptive_priority_scheduler_top] ERROR");
        $finish;
    end

endmodule
